FILE: rtl/core/irpd_pkg.sv
// package for the ir pulse-distance frame encoder core
// register map, reset durations, pulse slot codes and default frame shape
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

    // default frame shape
    localparam int SECTION_BYTES_DEF = 7;
    localparam int SECTION_COUNT_DEF = 2;

    // config port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int DUR_W   = 16;

    typedef enum logic [2:0] {
        REG_HEADER_MARK   = 3'd0,
        REG_HEADER_SPACE  = 3'd1,
        REG_SECTION_MARK  = 3'd2,
        REG_SECTION_SPACE = 3'd3,
        REG_SECTION_GAP   = 3'd4,
        REG_BIT_MARK      = 3'd5,
        REG_ONE_SPACE     = 3'd6,
        REG_ZERO_SPACE    = 3'd7
    } reg_idx_t;

    localparam logic [DUR_W-1:0] HEADER_MARK_RST   = 16'd690;
    localparam logic [DUR_W-1:0] HEADER_SPACE_RST  = 16'd17844;
    localparam logic [DUR_W-1:0] SECTION_MARK_RST  = 16'd3086;
    localparam logic [DUR_W-1:0] SECTION_SPACE_RST = 16'd8864;
    localparam logic [DUR_W-1:0] SECTION_GAP_RST   = 16'd2886;
    localparam logic [DUR_W-1:0] BIT_MARK_RST      = 16'd586;
    localparam logic [DUR_W-1:0] ONE_SPACE_RST     = 16'd1432;
    localparam logic [DUR_W-1:0] ZERO_SPACE_RST    = 16'd436;

    // pulse program of one byte: even slots are marks, odd slots spaces
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] SLOT_HDR_MARK   = 5'd0;
    localparam logic [STEP_W-1:0] SLOT_HDR_SPACE  = 5'd1;
    localparam logic [STEP_W-1:0] SLOT_SEC_MARK   = 5'd2;
    localparam logic [STEP_W-1:0] SLOT_SEC_SPACE  = 5'd3;
    localparam logic [STEP_W-1:0] SLOT_BIT_FIRST  = 5'd4;
    localparam logic [STEP_W-1:0] SLOT_BIT_LAST   = 5'd19;
    localparam logic [STEP_W-1:0] SLOT_FOOT_MARK  = 5'd20;
    localparam logic [STEP_W-1:0] SLOT_GAP        = 5'd21;

endpackage

`default_nettype wire

FILE: rtl/core/ir_pulse_distance_frame_encoder_core.sv
// ir pulse-distance frame encoder: byte in, mark/space duration beats out
// uses irpd_pkg for register map, reset durations and slot codes
// first pulse beat reaches m_valid through the byte register and then the output register
// throughput: one pulse beat per cycle while the receiver takes beats; a byte gives
//   16 to 22 beats, all passing through the single output register; the next
//   byte is taken in the cycle its predecessor's last beat enters the output
//   register
// reset: frame position back to the start of a frame, duration registers to
//   their default values, no beat pending
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_distance_frame_encoder_core #(
    parameter int SECTION_BYTES = irpd_pkg::SECTION_BYTES_DEF,
    parameter int SECTION_COUNT = irpd_pkg::SECTION_COUNT_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // apb-style config port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [irpd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [irpd_pkg::PDATA_W-1:0] pwdata,
    output logic      [irpd_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    // byte input channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [7:0]                   s_frame_byte,
    // pulse output channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_is_mark,
    output logic      [irpd_pkg::DUR_W-1:0]   m_duration_us,
    output logic                              m_last_of_run,
    output logic                              m_frame_done
);

    localparam int SB_W = (SECTION_BYTES > 1) ? $clog2(SECTION_BYTES) : 1;
    localparam int SC_W = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
    localparam int DW   = irpd_pkg::DUR_W;
    localparam int SW   = irpd_pkg::STEP_W;

    localparam logic [SB_W-1:0] SB_LAST = SB_W'(SECTION_BYTES - 1);
    localparam logic [SC_W-1:0] SC_LAST = SC_W'(SECTION_COUNT - 1);

    // ---------------------------------------------------------------
    // duration registers
    // ---------------------------------------------------------------
    logic [DW-1:0] hdr_mark_reg;
    logic [DW-1:0] hdr_space_reg;
    logic [DW-1:0] sec_mark_reg;
    logic [DW-1:0] sec_space_reg;
    logic [DW-1:0] sec_gap_reg;
    logic [DW-1:0] bit_mark_reg;
    logic [DW-1:0] one_space_reg;
    logic [DW-1:0] zero_space_reg;

    logic             cfg_write;
    irpd_pkg::reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = irpd_pkg::reg_idx_t'(paddr[irpd_pkg::PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_mark_reg   <= irpd_pkg::HEADER_MARK_RST;
            hdr_space_reg  <= irpd_pkg::HEADER_SPACE_RST;
            sec_mark_reg   <= irpd_pkg::SECTION_MARK_RST;
            sec_space_reg  <= irpd_pkg::SECTION_SPACE_RST;
            sec_gap_reg    <= irpd_pkg::SECTION_GAP_RST;
            bit_mark_reg   <= irpd_pkg::BIT_MARK_RST;
            one_space_reg  <= irpd_pkg::ONE_SPACE_RST;
            zero_space_reg <= irpd_pkg::ZERO_SPACE_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                irpd_pkg::REG_HEADER_MARK:   hdr_mark_reg   <= pwdata[DW-1:0];
                irpd_pkg::REG_HEADER_SPACE:  hdr_space_reg  <= pwdata[DW-1:0];
                irpd_pkg::REG_SECTION_MARK:  sec_mark_reg   <= pwdata[DW-1:0];
                irpd_pkg::REG_SECTION_SPACE: sec_space_reg  <= pwdata[DW-1:0];
                irpd_pkg::REG_SECTION_GAP:   sec_gap_reg    <= pwdata[DW-1:0];
                irpd_pkg::REG_BIT_MARK:      bit_mark_reg   <= pwdata[DW-1:0];
                irpd_pkg::REG_ONE_SPACE:     one_space_reg  <= pwdata[DW-1:0];
                irpd_pkg::REG_ZERO_SPACE:    zero_space_reg <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // register readback, zero-extended to the bus width
    always_comb begin
        case (cfg_idx)
            irpd_pkg::REG_HEADER_MARK:   prdata = irpd_pkg::PDATA_W'(hdr_mark_reg);
            irpd_pkg::REG_HEADER_SPACE:  prdata = irpd_pkg::PDATA_W'(hdr_space_reg);
            irpd_pkg::REG_SECTION_MARK:  prdata = irpd_pkg::PDATA_W'(sec_mark_reg);
            irpd_pkg::REG_SECTION_SPACE: prdata = irpd_pkg::PDATA_W'(sec_space_reg);
            irpd_pkg::REG_SECTION_GAP:   prdata = irpd_pkg::PDATA_W'(sec_gap_reg);
            irpd_pkg::REG_BIT_MARK:      prdata = irpd_pkg::PDATA_W'(bit_mark_reg);
            irpd_pkg::REG_ONE_SPACE:     prdata = irpd_pkg::PDATA_W'(one_space_reg);
            irpd_pkg::REG_ZERO_SPACE:    prdata = irpd_pkg::PDATA_W'(zero_space_reg);
            default:                     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // frame position: byte within section and section within frame
    // ---------------------------------------------------------------
    logic [SB_W-1:0] sec_byte_reg;
    logic [SC_W-1:0] sec_idx_reg;

    logic pos_first_frame;
    logic pos_first_sect;
    logic pos_last_sect;
    logic pos_last_frame;

    assign pos_first_sect  = (sec_byte_reg == '0);
    assign pos_first_frame = pos_first_sect && (sec_idx_reg == '0);
    assign pos_last_sect   = (sec_byte_reg == SB_LAST);
    assign pos_last_frame  = pos_last_sect && (sec_idx_reg == SC_LAST);

    // ---------------------------------------------------------------
    // byte register and slot sequencer
    // ---------------------------------------------------------------
    logic          busy_reg;
    logic [7:0]    byte_reg;
    logic [SW-1:0] step_reg;
    logic [SW-1:0] end_step_reg;
    logic          last_frame_reg;

    logic          out_adv;    // output register free to take a beat
    logic          last_slot;  // current slot is the byte's final beat
    logic          s_accept;
    logic [SW-1:0] start_step;
    logic [SW-1:0] end_step;

    assign out_adv   = !m_valid || m_ready;
    assign last_slot = (step_reg == end_step_reg);
    // new byte may enter while the previous one hands over its last beat
    assign s_ready   = !busy_reg || (out_adv && last_slot);
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        if (pos_first_frame) begin
            start_step = irpd_pkg::SLOT_HDR_MARK;
        end else if (pos_first_sect) begin
            start_step = irpd_pkg::SLOT_SEC_MARK;
        end else begin
            start_step = irpd_pkg::SLOT_BIT_FIRST;
        end
        end_step = pos_last_sect ? irpd_pkg::SLOT_GAP : irpd_pkg::SLOT_BIT_LAST;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            sec_byte_reg <= '0;
            sec_idx_reg  <= '0;
        end else begin
            if (s_accept) begin
                busy_reg <= 1'b1;
                // advance the frame position, wrapping after the last byte
                if (pos_last_sect) begin
                    sec_byte_reg <= '0;
                    sec_idx_reg  <= (sec_idx_reg == SC_LAST) ? '0 : sec_idx_reg + 1'b1;
                end else begin
                    sec_byte_reg <= sec_byte_reg + 1'b1;
                end
            end else if (busy_reg && out_adv && last_slot) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // payload side of the byte register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byte_reg       <= s_frame_byte;
            step_reg       <= start_step;
            end_step_reg   <= end_step;
            last_frame_reg <= pos_last_frame;
        end else if (busy_reg && out_adv) begin
            step_reg <= step_reg + 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // slot decode: duration of the current slot
    // ---------------------------------------------------------------
    logic [SW-2:0] pair_idx;
    logic [2:0]    bit_idx;
    logic [DW-1:0] slot_dur;

    // bit slots pair up as (mark, space); pair 2 is bit 0
    assign pair_idx = step_reg[SW-1:1] - (SW-1)'(2);
    assign bit_idx  = pair_idx[2:0];

    always_comb begin
        case (step_reg)
            irpd_pkg::SLOT_HDR_MARK:  slot_dur = hdr_mark_reg;
            irpd_pkg::SLOT_HDR_SPACE: slot_dur = hdr_space_reg;
            irpd_pkg::SLOT_SEC_MARK:  slot_dur = sec_mark_reg;
            irpd_pkg::SLOT_SEC_SPACE: slot_dur = sec_space_reg;
            irpd_pkg::SLOT_FOOT_MARK: slot_dur = bit_mark_reg;
            irpd_pkg::SLOT_GAP:       slot_dur = sec_gap_reg;
            default: begin
                // data bits, lsb first
                if (!step_reg[0]) begin
                    slot_dur = bit_mark_reg;
                end else if (byte_reg[bit_idx]) begin
                    slot_dur = one_space_reg;
                end else begin
                    slot_dur = zero_space_reg;
                end
            end
        endcase
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic          m_valid_reg;
    logic          m_is_mark_reg;
    logic [DW-1:0] m_duration_us_reg;
    logic          m_last_of_run_reg;
    logic          m_frame_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && busy_reg) begin
            m_is_mark_reg     <= !step_reg[0];
            m_duration_us_reg <= slot_dur;
            m_last_of_run_reg <= last_slot;
            m_frame_done_reg  <= last_frame_reg && (step_reg == irpd_pkg::SLOT_GAP);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_is_mark     = m_is_mark_reg;
    assign m_duration_us = m_duration_us_reg;
    assign m_last_of_run = m_last_of_run_reg;
    assign m_frame_done  = m_frame_done_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_done_is_last_space : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_last_of_run && !m_is_mark)
        else $error("frame_done beat is not the closing space of its byte");

    a_step_in_program : assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg <= end_step_reg && end_step_reg <= irpd_pkg::SLOT_GAP)
        else $error("slot sequencer ran past the end of the byte program");

    a_handover : assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && busy_reg |=> m_valid && m_last_of_run)
        else $error("new byte taken before the previous byte's last beat");

    a_frame_wrap : assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && pos_last_frame |=> sec_byte_reg == '0 && sec_idx_reg == '0)
        else $error("frame position did not wrap after the last byte");

endmodule

`default_nettype wire

FILE: tb/ir_pulse_distance_frame_encoder_core_test.sv
// self-checking testbench for ir_pulse_distance_frame_encoder_core
// drives frame bytes, checks every mark/space beat against a built-in pulse predictor
// depends on irpd_pkg and the core rtl only
`timescale 1ns / 1ps

module ir_pulse_distance_frame_encoder_core_test;
    import irpd_pkg::*;

    // frame shape under test, handed to the core as parameters
    localparam int SEC_BYTES   = SECTION_BYTES_DEF;
    localparam int SEC_COUNT   = SECTION_COUNT_DEF;
    localparam int FRAME_BYTES = SEC_BYTES * SEC_COUNT;

    localparam int RANDOM_BYTES = 74;     // per phase, six phases
    localparam int SETTLE_CYC   = 30;     // quiet cycles after the last beat
    localparam int HOLD_CYC     = 400;    // long receiver hold-off
    localparam int CYCLE_LIMIT  = 500000;

    // one expected beat on the pulse channel
    typedef struct {
        logic             is_mark;
        logic [DUR_W-1:0] duration_us;
        logic             last_of_run;
        logic             frame_done;
    } pulse_t;

    // pulse predictor plus the queue of beats still owed by the core
    class pulse_scoreboard;
        logic [DUR_W-1:0] dur_reg [8];
        int unsigned      frame_pos;
        pulse_t           owed_q [$];
        int               fail_count;
        int               beats_checked;

        function new();
            dur_reg[REG_HEADER_MARK]   = HEADER_MARK_RST;
            dur_reg[REG_HEADER_SPACE]  = HEADER_SPACE_RST;
            dur_reg[REG_SECTION_MARK]  = SECTION_MARK_RST;
            dur_reg[REG_SECTION_SPACE] = SECTION_SPACE_RST;
            dur_reg[REG_SECTION_GAP]   = SECTION_GAP_RST;
            dur_reg[REG_BIT_MARK]      = BIT_MARK_RST;
            dur_reg[REG_ONE_SPACE]     = ONE_SPACE_RST;
            dur_reg[REG_ZERO_SPACE]    = ZERO_SPACE_RST;
            frame_pos     = 0;
            fail_count    = 0;
            beats_checked = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [DUR_W-1:0] val);
            dur_reg[idx] = val;
        endfunction

        function int owed();
            return owed_q.size();
        endfunction

        function void owe(logic is_mark, logic [DUR_W-1:0] dur, logic done);
            pulse_t p;
            p.is_mark     = is_mark;
            p.duration_us = dur;
            p.last_of_run = 1'b0;
            p.frame_done  = done;
            owed_q.push_back(p);
        endfunction

        // expand one accepted byte into its pulse train
        function void note_byte(logic [7:0] fbyte);
            int unsigned in_sec;
            in_sec = frame_pos % SEC_BYTES;
            if (frame_pos == 0) begin
                owe(1'b1, dur_reg[REG_HEADER_MARK], 1'b0);
                owe(1'b0, dur_reg[REG_HEADER_SPACE], 1'b0);
            end
            if (in_sec == 0) begin
                owe(1'b1, dur_reg[REG_SECTION_MARK], 1'b0);
                owe(1'b0, dur_reg[REG_SECTION_SPACE], 1'b0);
            end
            for (int i = 0; i < 8; i++) begin
                owe(1'b1, dur_reg[REG_BIT_MARK], 1'b0);
                owe(1'b0, fbyte[i] ? dur_reg[REG_ONE_SPACE] : dur_reg[REG_ZERO_SPACE], 1'b0);
            end
            if (in_sec == SEC_BYTES - 1) begin
                owe(1'b1, dur_reg[REG_BIT_MARK], 1'b0);
                owe(1'b0, dur_reg[REG_SECTION_GAP], frame_pos == FRAME_BYTES - 1);
            end
            owed_q[owed_q.size() - 1].last_of_run = 1'b1;
            frame_pos = (frame_pos + 1 >= FRAME_BYTES) ? 0 : frame_pos + 1;
        endfunction

        function void cmp_field(string fname, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v,
                         got_v);
                fail_count++;
            end
        endfunction

        function void check_pulse(logic is_mark, logic [DUR_W-1:0] dur, logic last,
                                  logic done);
            pulse_t p;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual mark=%0d dur=%0d",
                         $time, is_mark, dur);
                fail_count++;
                return;
            end
            p = owed_q.pop_front();
            beats_checked++;
            cmp_field("is_mark", p.is_mark, is_mark);
            cmp_field("duration_us", p.duration_us, dur);
            cmp_field("last_of_run", p.last_of_run, last);
            cmp_field("frame_done", p.frame_done, done);
        endfunction
    endclass

    // clock, reset and every core input start at known values
    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [7:0]         s_frame_byte  = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic               m_is_mark;
    logic [DUR_W-1:0]   m_duration_us;
    logic               m_last_of_run;
    logic               m_frame_done;

    pulse_scoreboard sb = new();

    int idle_pct  = 0;    // chance in a hundred that the sender skips a cycle
    int stall_pct = 0;    // chance in a hundred that the receiver stalls
    bit hold_req  = 1'b0; // ask the receiver for one long hold-off
    int bytes_sent  = 0;
    int reg_writes  = 0;
    int cycle_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    ir_pulse_distance_frame_encoder_core #(
        .SECTION_BYTES(SEC_BYTES),
        .SECTION_COUNT(SEC_COUNT)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_byte  (s_frame_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_mark     (m_is_mark),
        .m_duration_us (m_duration_us),
        .m_last_of_run (m_last_of_run),
        .m_frame_done  (m_frame_done)
    );

    // pulse receiver: checks each accepted beat, then picks next cycle's ready;
    // the long hold-off is counted here so the sender keeps pushing meanwhile
    int hold_left = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_pulse(m_is_mark, m_duration_us, m_last_of_run, m_frame_done);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYC;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats still owed", cycle_count, sb.owed());
        $display("FAIL ir_pulse_distance_frame_encoder_core");
        $finish;
    end

    // offer one byte; valid is only dropped inside a gap, never in the accept step
    task automatic send_byte(input logic [7:0] fbyte);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_frame_byte <= fbyte;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(fbyte);
        bytes_sent++;
    endtask

    // wait until every owed beat came back, then let the core settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.owed() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // apb write: setup then access; upper data bits are junk the core must drop
    task automatic write_reg(input reg_idx_t idx, input logic [DUR_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
        reg_writes++;
        @(posedge aclk);
    endtask

    // apb read back against the predictor's copy of the register
    task automatic read_reg(input reg_idx_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[DUR_W-1:0] !== sb.dur_reg[idx]) begin
            $display("%0t: readback of %s mismatch, expected %0d, actual %0d", $time,
                     idx.name(), sb.dur_reg[idx], prdata[DUR_W-1:0]);
            sb.fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // directed bytes: extremes, single bits, alternating patterns; 16 bytes also
    // run past the end of the first frame so the position wraps into a new header
    logic [7:0] directed_bytes [16] = '{
        8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
    };

    initial begin
        logic [DUR_W-1:0] val;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset durations, no idling on either side
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            // new duration setting, written only while the core is idle
            for (int r = 0; r < 8; r++) begin
                case (phase)
                    0: val = '0;                     // zero durations
                    1: val = '1;                     // largest durations
                    5: val = sb.dur_reg[r] ^ 16'hFFFF;
                    default: val = DUR_W'($urandom_range(65535));
                endcase
                write_reg(reg_idx_t'(r), val);
            end
            for (int r = 0; r < 8; r++) read_reg(reg_idx_t'(r));

            // idling mix for this phase
            case (phase)
                0: begin idle_pct = 35; stall_pct = 35; end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                3: begin idle_pct = 0;  stall_pct = 0;  end
                4: begin idle_pct = 0;  stall_pct = 0;  hold_req = 1'b1; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase

            repeat (RANDOM_BYTES) send_byte(8'($urandom_range(255)));
            drain();
        end

        $display("covered %0d frame bytes over 7 duration settings, %0d register writes",
                 bytes_sent, reg_writes);
        $display("%0d pulse beats checked, with sender gaps, receiver stalls and one long hold-off",
                 sb.beats_checked);
        if (sb.fail_count == 0) begin
            $display("PASS ir_pulse_distance_frame_encoder_core");
        end else begin
            $display("FAIL ir_pulse_distance_frame_encoder_core");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/irpd_pkg.sv
rtl/core/ir_pulse_distance_frame_encoder_core.sv
tb/ir_pulse_distance_frame_encoder_core_test.sv
